/* sv/brs_pkg.sv */
`default_nettype none
package brs_pkg;

   localparam int CordicSteps = 24;
   localparam int CordicStepBits = 5;

   localparam int AngW = 33;
   localparam int VecW = 34;

   localparam logic signed [AngW-1:0] Deg22_90  = 33'sd377487360;
   localparam logic signed [AngW-1:0] Deg22_180 = 33'sd754974720;
   localparam logic signed [AngW-1:0] Deg22_360 = 33'sd1509949440;
   localparam logic signed [26:0] Deg16_180 = 27'sd11796480;
   localparam logic signed [26:0] Deg16_360 = 27'sd23592960;
   localparam logic signed [VecW-1:0] CordicK = 34'sd652032874;

   localparam logic [1:0] CsrDeadband = 2'd0;
   localparam logic [1:0] CsrLimit    = 2'd1;

   typedef enum logic {ModeRotate, ModeVector} cmode_type;

   typedef struct packed {
      logic signed [VecW-1:0] x;
      logic signed [VecW-1:0] y;
      logic signed [AngW-1:0] z;
   } cvec_type;

   function automatic logic signed [AngW-1:0] atan_entry(input logic [CordicStepBits-1:0] i);
      logic signed [AngW-1:0] t;
      unique case (i)
         5'd0: t = 33'sd188743680;  5'd1: t = 33'sd111421900;
         5'd2: t = 33'sd58872272;   5'd3: t = 33'sd29884485;
         5'd4: t = 33'sd15000234;   5'd5: t = 33'sd7507429;
         5'd6: t = 33'sd3754631;    5'd7: t = 33'sd1877430;
         5'd8: t = 33'sd938729;     5'd9: t = 33'sd469366;
         5'd10: t = 33'sd234683;    5'd11: t = 33'sd117342;
         5'd12: t = 33'sd58671;     5'd13: t = 33'sd29335;
         5'd14: t = 33'sd14668;     5'd15: t = 33'sd7334;
         5'd16: t = 33'sd3667;      5'd17: t = 33'sd1833;
         5'd18: t = 33'sd917;       5'd19: t = 33'sd458;
         5'd20: t = 33'sd229;       5'd21: t = 33'sd115;
         5'd22: t = 33'sd57;        5'd23: t = 33'sd29;
         5'd24: t = 33'sd14;        5'd25: t = 33'sd7;
         5'd26: t = 33'sd4;         5'd27: t = 33'sd2;
         5'd28: t = 33'sd1;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

/* sv/bearing_rudder_steering.sv */
// Steering core: takes heading, current and goal position per transfer and returns the
// great-circle initial bearing, the angle to goal, turn direction and a proportional rudder
// command. Fully pipelined: one transfer per cycle sustained while the output is not stalled;
// the datapath is two chains of CORDIC cells (sin/cos rotation, then atan2 vectoring) with the
// product stages between them. The whole pipeline advances only when the result register is
// free or being taken; csr writes are always ready and apply to every result that passes the
// turn logic after the write, so write only while nothing is in flight.
`default_nettype none
module bearing_rudder_steering (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic signed [24:0] req_heading,
   input  wire logic signed [29:0] req_cur_lat,
   input  wire logic signed [30:0] req_cur_lon,
   input  wire logic signed [29:0] req_goal_lat,
   input  wire logic signed [30:0] req_goal_lon,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic signed [23:0] rsp_rudder_cmd,
   output      logic [24:0]        rsp_bearing,
   output      logic [23:0]        rsp_angle_to_goal,
   output      logic               rsp_turn_left,
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [23:0]        csr_data
);

   localparam int N = brs_pkg::CordicSteps;
   localparam int AW = brs_pkg::AngW;
   localparam int VW = brs_pkg::VecW;
   localparam int Lat = 2 * N + 7;

   logic adv;
   logic [Lat-1:0] vld_ff;
   logic [23:0] dead_ff;
   logic [22:0] lim_ff;

   assign csr_ready = 1'b1;
   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_ff <= 24'd327680;
         lim_ff <= 23'd2949120;
      end else if (csr_valid) begin
         if (csr_index == brs_pkg::CsrDeadband) dead_ff <= csr_data;
         else if (csr_index == brs_pkg::CsrLimit) lim_ff <= csr_data[22:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[Lat-2:0], req_valid};
   end

   // stage 0: range reduction
   function automatic logic signed [AW:0] reduce(input logic signed [AW-1:0] a);
      logic signed [AW-1:0] r;
      logic neg;
      r = a;
      if (r >= brs_pkg::Deg22_180) r = r - brs_pkg::Deg22_360;
      else if (r < -brs_pkg::Deg22_180) r = r + brs_pkg::Deg22_360;
      neg = 1'b0;
      if (r > brs_pkg::Deg22_90) begin
         r = r - brs_pkg::Deg22_180; neg = 1'b1;
      end else if (r < -brs_pkg::Deg22_90) begin
         r = r + brs_pkg::Deg22_180; neg = 1'b1;
      end
      return {neg, r};
   endfunction

   logic signed [AW-1:0] dlon;
   logic signed [AW:0] rc, rg, rd;
   assign dlon = AW'(req_goal_lon) - AW'(req_cur_lon);
   assign rc = reduce(AW'(req_cur_lat));
   assign rg = reduce(AW'(req_goal_lat));
   assign rd = reduce(dlon);

   brs_pkg::cvec_type s0_ff [3];
   logic [2:0] neg0_ff;
   logic signed [26:0] head0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff[0] <= '{x: brs_pkg::CordicK, y: '0, z: rc[AW-1:0]};
         s0_ff[1] <= '{x: brs_pkg::CordicK, y: '0, z: rg[AW-1:0]};
         s0_ff[2] <= '{x: brs_pkg::CordicK, y: '0, z: rd[AW-1:0]};
         neg0_ff <= {rd[AW], rg[AW], rc[AW]};
         head0_ff <= req_heading[24] ? 27'(req_heading) + brs_pkg::Deg16_360
                                     : 27'(req_heading);
      end
   end

   brs_pkg::cvec_type sc [3];
   for (genvar g = 0; g < 3; g++) begin : g_rot
      brs_cordic_chain u_rot (
         .clock(clock), .enable(adv), .mode(brs_pkg::ModeRotate),
         .vec_in(s0_ff[g]), .vec_out(sc[g]));
   end

   logic [2:0] neg_d [N];
   logic signed [26:0] head_d [Lat-2];
   always_ff @(posedge clock) begin
      if (adv) begin
         neg_d[0] <= neg0_ff;
         for (int k = 1; k < N; k++) neg_d[k] <= neg_d[k-1];
         head_d[0] <= head0_ff;
         for (int k = 1; k < Lat - 2; k++) head_d[k] <= head_d[k-1];
      end
   end

   // stage A: apply fold sign, sin/cos at 32 bits
   logic signed [31:0] scl_ff, ccl_ff, sgl_ff, cgl_ff, sdl_ff, cdl_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         scl_ff <= 32'(neg_d[N-1][0] ? -sc[0].y : sc[0].y);
         ccl_ff <= 32'(neg_d[N-1][0] ? -sc[0].x : sc[0].x);
         sgl_ff <= 32'(neg_d[N-1][1] ? -sc[1].y : sc[1].y);
         cgl_ff <= 32'(neg_d[N-1][1] ? -sc[1].x : sc[1].x);
         sdl_ff <= 32'(neg_d[N-1][2] ? -sc[2].y : sc[2].y);
         cdl_ff <= 32'(neg_d[N-1][2] ? -sc[2].x : sc[2].x);
      end
   end

   // stage B: first products
   logic signed [63:0] ny_ff, p1_ff, p2_ff;
   logic signed [31:0] cdl_b_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         ny_ff <= sdl_ff * cgl_ff;
         p1_ff <= ccl_ff * sgl_ff;
         p2_ff <= scl_ff * cgl_ff;
         cdl_b_ff <= cdl_ff;
      end
   end

   // stage C: triple product
   logic signed [63:0] ny_c_ff, p1_c_ff, p3_ff;
   logic signed [33:0] p2s;
   assign p2s = 34'(p2_ff >>> 30);
   always_ff @(posedge clock) begin
      if (adv) begin
         ny_c_ff <= ny_ff;
         p1_c_ff <= p1_ff;
         p3_ff <= 64'(p2s * cdl_b_ff);
      end
   end

   // stage D: atan2 setup
   logic signed [63:0] nx;
   logic signed [VW-1:0] ay, ax;
   assign nx = p1_c_ff - p3_ff;
   assign ay = VW'(ny_c_ff >>> 30);
   assign ax = VW'(nx >>> 30);

   brs_pkg::cvec_type v0_ff;
   logic zero_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff <= (ax == '0) && (ay == '0);
         if (ax[VW-1])
            v0_ff <= '{x: -ax, y: -ay,
                       z: ay[VW-1] ? -brs_pkg::Deg22_180 : brs_pkg::Deg22_180};
         else
            v0_ff <= '{x: ax, y: ay, z: '0};
      end
   end

   brs_pkg::cvec_type vo;
   brs_cordic_chain u_vec (
      .clock(clock), .enable(adv), .mode(brs_pkg::ModeVector),
      .vec_in(v0_ff), .vec_out(vo));

   logic zero_d [N];
   always_ff @(posedge clock) begin
      if (adv) begin
         zero_d[0] <= zero_ff;
         for (int k = 1; k < N; k++) zero_d[k] <= zero_d[k-1];
      end
   end

   // stage E: bearing in deg*65536
   logic signed [AW-1:0] zr;
   logic signed [26:0] b0;
   logic [24:0] brg_ff;
   assign zr = (vo.z + AW'(32)) >>> 6;
   assign b0 = 27'(zr);
   always_ff @(posedge clock) begin
      if (adv) begin
         if (zero_d[N-1]) brg_ff <= '0;
         else if (b0[26]) brg_ff <= 25'(b0 + brs_pkg::Deg16_360);
         else if (b0 >= brs_pkg::Deg16_360) brg_ff <= 25'(b0 - brs_pkg::Deg16_360);
         else brg_ff <= 25'(b0);
      end
   end

   // stage F: turn logic
   logic signed [27:0] prov, turn, mag;
   logic signed [27:0] ang;
   assign prov = 28'($signed({3'b0, brg_ff})) - 28'(head_d[Lat-3]);
   always_comb begin
      if (prov > 28'(brs_pkg::Deg16_180)) turn = prov - 28'(brs_pkg::Deg16_360);
      else if (prov <= -28'(brs_pkg::Deg16_180)) turn = prov + 28'(brs_pkg::Deg16_360);
      else turn = prov;
      mag = prov[27] ? -prov : prov;
      ang = (mag >= 28'(brs_pkg::Deg16_360)) ? mag - 28'(brs_pkg::Deg16_360) : mag;
      if (ang > 28'(brs_pkg::Deg16_180)) ang = 28'(brs_pkg::Deg16_360) - ang;
   end

   logic [24:0] brg_o_ff;
   logic [23:0] ang_ff;
   logic left_ff;
   logic signed [23:0] rud_ff;
   logic [23:0] rmag;
   always_comb begin
      if (ang[23:0] < dead_ff) rmag = '0;
      else rmag = ang[24:1];
      if (rmag > {1'b0, lim_ff}) rmag = {1'b0, lim_ff};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         brg_o_ff <= brg_ff;
         ang_ff <= ang[23:0];
         left_ff <= turn[27];
         rud_ff <= turn[27] ? -$signed(rmag) : $signed(rmag);
      end
   end

   assign rsp_valid = vld_ff[Lat-1];
   assign rsp_rudder_cmd = rud_ff;
   assign rsp_bearing = brg_o_ff;
   assign rsp_angle_to_goal = ang_ff;
   assign rsp_turn_left = left_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bearing))
      else $error("held result changed");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bearing < 25'd23592960)
      else $error("bearing out of range");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle_to_goal <= 24'd11796480)
      else $error("angle out of range");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_turn_left |-> !rsp_rudder_cmd[23])
      else $error("rudder sign mismatch");

endmodule
`default_nettype wire

/* sv/brs_cordic_cell.sv */
`default_nettype none
module brs_cordic_cell (
   input  wire logic                                  clock,
   input  wire logic                                  enable,
   input  wire logic [brs_pkg::CordicStepBits-1:0]    step,
   input  wire brs_pkg::cmode_type                    mode,
   input  wire brs_pkg::cvec_type                     vec_in,
   output      brs_pkg::cvec_type                     vec_out
);

   brs_pkg::cvec_type vec_ff, vec_in_c;
   logic signed [brs_pkg::VecW-1:0] dx, dy;
   logic up;

   always_comb begin
      dx = vec_in.y >>> step;
      dy = vec_in.x >>> step;
      up = (mode == brs_pkg::ModeRotate) ? !vec_in.z[brs_pkg::AngW-1]
                                         : vec_in.y[brs_pkg::VecW-1];
      if (up) begin
         vec_in_c.x = vec_in.x - dx;
         vec_in_c.y = vec_in.y + dy;
      end else begin
         vec_in_c.x = vec_in.x + dx;
         vec_in_c.y = vec_in.y - dy;
      end
      if (up)
         vec_in_c.z = vec_in.z - brs_pkg::atan_entry(step);
      else
         vec_in_c.z = vec_in.z + brs_pkg::atan_entry(step);
   end

   always_ff @(posedge clock) begin
      if (enable)
         vec_ff <= vec_in_c;
   end

   assign vec_out = vec_ff;

endmodule
`default_nettype wire

/* sv/brs_cordic_chain.sv */
`default_nettype none
module brs_cordic_chain (
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire brs_pkg::cmode_type mode,
   input  wire brs_pkg::cvec_type  vec_in,
   output      brs_pkg::cvec_type  vec_out
);

   brs_pkg::cvec_type link [brs_pkg::CordicSteps+1];

   assign link[0] = vec_in;

   for (genvar g = 0; g < brs_pkg::CordicSteps; g++) begin : g_cell
      brs_cordic_cell u_cell (
         .clock  (clock),
         .enable (enable),
         .step   (brs_pkg::CordicStepBits'(g)),
         .mode   (mode),
         .vec_in (link[g]),
         .vec_out(link[g+1])
      );
   end

   assign vec_out = link[brs_pkg::CordicSteps];

endmodule
`default_nettype wire

/* verif/tb_bearing_rudder_steering.sv */
`timescale 1ns / 100ps
module tb_bearing_rudder_steering;

   localparam longint D22_90 = 377487360;
   localparam longint D22_180 = 754974720;
   localparam longint D22_360 = 1509949440;
   localparam longint D16_180 = 11796480;
   localparam longint D16_360 = 23592960;
   localparam longint GainK = 652032874;
   localparam logic [1:0] CsrUnused = 2'd3;

   localparam longint ArcTab [0:28] = '{
      188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
      3754631, 1877430, 938729, 469366, 234683, 117342,
      58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
      229, 115, 57, 29, 14, 7, 4, 2, 1};

   typedef enum {OpItem, OpCsr, OpDrain} op_type;

   typedef struct {
      op_type            op;
      logic signed [24:0] heading;
      logic signed [29:0] cur_lat;
      logic signed [30:0] cur_lon;
      logic signed [29:0] goal_lat;
      logic signed [30:0] goal_lon;
      logic [1:0]         index;
      logic [23:0]        data;
   } pend_type;

   typedef struct {
      logic signed [23:0] rudder;
      logic [24:0]        bearing;
      logic [23:0]        angle;
      logic               left;
   } steer_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [24:0] req_heading = '0;
   logic signed [29:0] req_cur_lat = '0;
   logic signed [30:0] req_cur_lon = '0;
   logic signed [29:0] req_goal_lat = '0;
   logic signed [30:0] req_goal_lon = '0;
   logic rsp_valid;
   logic rsp_stall = 1;
   logic signed [23:0] rsp_rudder_cmd;
   logic [24:0] rsp_bearing;
   logic [23:0] rsp_angle_to_goal;
   logic rsp_turn_left;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [23:0] csr_data = '0;

   bearing_rudder_steering dut (.*);

   pend_type pending[$];
   steer_type steer_exp[$];
   logic [23:0] deadband = 24'd327680;
   logic [22:0] limit = 23'd2949120;
   int errors = 0;
   int req_xfers = 0, req_sent = 0, csr_xfers = 0, csr_sent = 0;
   int rsp_count = 0, rsp_seen = 0, quiet = 0, cyc = 0;
   int send_gap = 0, recv_gap = 0, hold = 0;
   bit hold_done = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint modp(longint a, longint m);
      longint r;
      r = a % m;
      if (r < 0) r += m;
      return r;
   endfunction

   function automatic void sin_cos(input longint a, output longint s, output longint c);
      longint r, x, y, z, dx, dy;
      bit neg;
      r = modp(a, D22_360);
      neg = 0;
      x = GainK;
      y = 0;
      if (r >= D22_180) r -= D22_360;
      if (r > D22_90) begin
         r -= D22_180;
         neg = 1;
      end else if (r < -D22_90) begin
         r += D22_180;
         neg = 1;
      end
      z = r;
      for (int i = 0; i < brs_pkg::CordicSteps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ArcTab[i];
         end else begin
            x += dx; y -= dy; z += ArcTab[i];
         end
      end
      s = neg ? -y : y;
      c = neg ? -x : x;
   endfunction

   function automatic longint arc_tan2(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? D22_180 : -D22_180;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < brs_pkg::CordicSteps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += ArcTab[i];
         end else begin
            x -= dx; y += dy; z -= ArcTab[i];
         end
      end
      return z;
   endfunction

   function automatic steer_type steer_predict(longint head, longint clat, longint clon,
                                               longint glat, longint glon);
      longint scl, ccl, sgl, cgl, sdl, cdl, ny, nx, z, brg, prov, turn, ang, rud;
      steer_type r;
      if (head < 0) head += D16_360;
      sin_cos(clat, scl, ccl);
      sin_cos(glat, sgl, cgl);
      sin_cos(glon - clon, sdl, cdl);
      ny = sdl * cgl;
      nx = ccl * sgl - ((scl * cgl) >>> 30) * cdl;
      z = arc_tan2(ny >>> 30, nx >>> 30);
      brg = modp(((z + 32) >>> 6) + D16_360, D16_360);
      prov = brg - head;
      if (prov > D16_180) turn = prov - D16_360;
      else if (prov <= -D16_180) turn = prov + D16_360;
      else turn = prov;
      ang = modp(prov < 0 ? -prov : prov, D16_360);
      if (ang > D16_180) ang = D16_360 - ang;
      rud = (ang < longint'(deadband)) ? 0 : ang >>> 1;
      if (rud > longint'(limit)) rud = longint'(limit);
      if (turn < 0) rud = -rud;
      r.rudder = rud[23:0];
      r.bearing = brg[24:0];
      r.angle = ang[23:0];
      r.left = turn < 0;
      return r;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s at result %0d: got %0d want %0d", what, rsp_count, got, want);
      errors++;
   endtask

   function automatic int draw_gap();
      if ((cyc / 700) % 4 == 0) return 0;
      return $urandom_range(0, 18);
   endfunction

   task automatic add_item(longint h, longint cl, longint co, longint gl, longint go);
      pend_type p;
      p.op = OpItem;
      p.heading = h[24:0];
      p.cur_lat = cl[29:0];
      p.cur_lon = co[30:0];
      p.goal_lat = gl[29:0];
      p.goal_lon = go[30:0];
      p.index = '0;
      p.data = '0;
      pending.push_back(p);
   endtask

   task automatic add_csr(logic [1:0] idx, logic [23:0] val);
      pend_type p;
      p = '{op: OpCsr, default: '0};
      p.index = idx;
      p.data = val;
      pending.push_back(p);
   endtask

   task automatic add_drain();
      pend_type p;
      p = '{op: OpDrain, default: '0};
      pending.push_back(p);
   endtask

   task automatic add_random();
      longint h, cl, co, gl, go;
      steer_type b;
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) begin
         h = $signed(25'($urandom()));
         cl = $signed(30'($urandom()));
         co = $signed(31'($urandom()));
         gl = $signed(30'($urandom()));
         go = $signed(31'($urandom()));
      end else begin
         h = longint'($urandom_range(0, 23592960)) - D16_180;
         cl = longint'($urandom_range(0, 754974720)) - D22_90;
         co = longint'($urandom_range(0, 1509949440)) - D22_180;
         if (k < 3) begin
            gl = cl + longint'($urandom_range(0, 8000000)) - 4000000;
            go = co + longint'($urandom_range(0, 8000000)) - 4000000;
            if (gl > D22_90) gl = D22_90;
            if (gl < -D22_90) gl = -D22_90;
            if (go > D22_180) go = D22_180;
            if (go < -D22_180) go = -D22_180;
         end else begin
            gl = longint'($urandom_range(0, 754974720)) - D22_90;
            go = longint'($urandom_range(0, 1509949440)) - D22_180;
         end
         if (k < 6) begin
            b = steer_predict(0, cl, co, gl, go);
            h = longint'(b.bearing) + longint'($urandom_range(0, 1400000)) - 700000;
            h = modp(h, D16_360);
            if (h > D16_180) h -= D16_360;
         end
      end
      add_item(h, cl, co, gl, go);
   endtask

   // stimulus
   initial begin
      add_item(0, 0, 0, 0, 0);
      add_item(D16_180, D22_90, D22_180, -D22_90, -D22_180);
      add_item(-D16_180, -D22_90, -D22_180, D22_90, D22_180);
      add_item(-D16_180, 0, 0, 4194304, 0);
      add_item(D16_180, 0, 0, 4194304, 0);
      add_item(0, 0, 0, -4194304, 0);
      add_item(-16777216, 0, 0, 0, 4194304);
      add_item(16777215, 0, 0, 0, -4194304);
      add_item(0, -536870912, -1073741824, 536870911, 1073741823);
      add_item(0, 536870911, 1073741823, -536870912, -1073741824);
      add_item(1, 100, 200, 100, 200);
      add_item(-1, 0, D22_180, 0, -D22_180);
      add_item(5898240, 0, 0, 0, D22_180);
      add_item(-5898240, 0, 0, 0, -D22_90);
      add_item(327680, 0, 0, 1000000, 100000);
      add_item(0, D22_90, 0, D22_90, 12345);
      add_item(11796479, 0, 0, -1, 0);
      add_item(-11796479, -2000000, 3000000, -1000000, 2000000);
      add_item(655360, 20000000, -30000000, 20100000, -29900000);
      add_item(-655360, -20000000, 30000000, -20100000, 29900000);
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               add_csr(brs_pkg::CsrDeadband, 24'd0);
               add_csr(brs_pkg::CsrLimit, 24'h7FFFFF);
            end
            1: begin
               add_csr(brs_pkg::CsrDeadband, 24'hFFFFFF);
               add_csr(brs_pkg::CsrLimit, 24'd0);
            end
            2: begin
               add_csr(brs_pkg::CsrDeadband, 24'd11796480);
               add_csr(brs_pkg::CsrLimit, 24'hFFFFFF);
            end
            3: begin
               add_csr(brs_pkg::CsrDeadband, 24'($urandom_range(0, 11796480)));
               add_csr(brs_pkg::CsrLimit, 24'($urandom_range(0, 5898240)));
               add_csr(CsrUnused, 24'hFFFFFF);
            end
            4: begin
               add_csr(brs_pkg::CsrDeadband, 24'd327680);
               add_csr(brs_pkg::CsrLimit, 24'd5898240);
            end
            default: begin
               add_csr(brs_pkg::CsrDeadband, 24'd655360);
               add_csr(brs_pkg::CsrLimit, 24'd2949120);
            end
         endcase
         for (int n = 0; n < 130; n++) begin
            if (ph == 2 && n == 60) add_drain();
            add_random();
         end
      end
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 0;
      @(posedge clock);
      while (pending.size() != 0 || req_valid || csr_valid || steer_exp.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
      if (errors == 0 && steer_exp.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #3000000;
      $display("DONE: errors detected");
      $finish;
   end

   // sender
   always @(negedge clock) begin
      logic nv, nc;
      nv = req_valid;
      nc = csr_valid;
      if (req_valid && req_xfers == req_sent) nv = 0;
      if (csr_valid && csr_xfers == csr_sent) nc = 0;
      if (!reset && !nv && !nc && pending.size() > 0) begin
         if (send_gap > 0) send_gap--;
         else case (pending[0].op)
            OpItem: begin
               req_heading <= pending[0].heading;
               req_cur_lat <= pending[0].cur_lat;
               req_cur_lon <= pending[0].cur_lon;
               req_goal_lat <= pending[0].goal_lat;
               req_goal_lon <= pending[0].goal_lon;
               nv = 1;
               req_sent++;
               void'(pending.pop_front());
               send_gap = draw_gap();
            end
            OpCsr: if (steer_exp.size() == 0 && quiet >= 70) begin
               csr_index <= pending[0].index;
               csr_data <= pending[0].data;
               nc = 1;
               csr_sent++;
               void'(pending.pop_front());
            end
            default: if (steer_exp.size() == 0) void'(pending.pop_front());
         endcase
      end
      req_valid <= nv;
      csr_valid <= nc;
   end

   // receiver
   always @(negedge clock) begin
      if (rsp_seen != rsp_count) begin
         rsp_seen = rsp_count;
         recv_gap = draw_gap();
      end
      if (!hold_done && rsp_count >= 300) begin
         hold_done = 1;
         hold = 500;
      end
      if (reset) rsp_stall <= 1;
      else if (hold > 0) begin
         hold--;
         rsp_stall <= 1;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_stall <= 1;
      end else rsp_stall <= 0;
   end

   // monitor
   always @(posedge clock) begin
      steer_type e;
      cyc++;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            steer_exp.push_back(steer_predict(req_heading, req_cur_lat, req_cur_lon,
                                              req_goal_lat, req_goal_lon));
            req_xfers++;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == brs_pkg::CsrDeadband) deadband = csr_data;
            else if (csr_index == brs_pkg::CsrLimit) limit = csr_data[22:0];
            csr_xfers++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (steer_exp.size() == 0) report("unexpected transfer", 0, 0);
            else begin
               e = steer_exp.pop_front();
               if (rsp_rudder_cmd !== e.rudder)
                  report("rudder_cmd", rsp_rudder_cmd, e.rudder);
               if (rsp_bearing !== e.bearing) report("bearing", rsp_bearing, e.bearing);
               if (rsp_angle_to_goal !== e.angle)
                  report("angle_to_goal", rsp_angle_to_goal, e.angle);
               if (rsp_turn_left !== e.left) report("turn_left", rsp_turn_left, e.left);
            end
            rsp_count++;
            quiet = 0;
         end else quiet++;
      end
   end

endmodule
